/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms used by the checker of this block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ps2cq_pkg.sv */
// ---------------------------------------------------------------------------
// PS/2 command queue package
// Word types, function codes and reply codes of the command queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2cq_pkg;

  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_RX   = 2'd1,
    FUNC_POLL = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  localparam logic [7:0] ACK_CODE          = 8'hFA;
  localparam logic [7:0] RESEND_CODE       = 8'hFE;
  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

  typedef struct packed {
    func_t      func;
    logic [7:0] cmd_byte;
    logic [7:0] arg_byte;
    logic [7:0] rx_byte;
    logic       ctrl_out_full;
  } req_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic       pass_valid;
    logic [7:0] pass_byte;
    logic       gave_up;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

/* sv/ps2cq_store.sv */
// ---------------------------------------------------------------------------
// PS/2 command queue store
// Byte store split into even and odd banks so that a command and its
// argument are written in the same cycle; one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2cq_store #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_pos,
  input  logic [7:0]                     wr_cmd,
  input  logic [7:0]                     wr_arg,
  input  logic                           rd_en,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_pos,
  output logic [7:0]                     rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int BD = (QUEUE_DEPTH + 1) / 2;

  logic [7:0]    even_mem [BD];
  logic [7:0]    odd_mem  [BD];
  logic [PW-1:0] arg_pos;
  logic [PW-2:0] wr_hi;
  logic [PW-2:0] arg_hi;
  logic [PW-2:0] rd_hi;
  logic [7:0]    even_q;
  logic [7:0]    odd_q;
  logic          odd_sel;
  logic          fwd;
  logic [7:0]    fwd_byte;

  assign arg_pos = wr_pos + PW'(1);
  assign wr_hi   = wr_pos[PW-1:1];
  assign arg_hi  = arg_pos[PW-1:1];
  assign rd_hi   = rd_pos[PW-1:1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (!wr_pos[0]) begin
        even_mem[wr_hi]  <= wr_cmd;
        odd_mem[arg_hi]  <= wr_arg;
      end else begin
        odd_mem[wr_hi]   <= wr_cmd;
        even_mem[arg_hi] <= wr_arg;
      end
    end
  end

  // a send in the cycle of its own write only ever reads the command slot
  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q   <= even_mem[rd_hi];
      odd_q    <= odd_mem[rd_hi];
      odd_sel  <= rd_pos[0];
      fwd      <= wr_en && (rd_pos == wr_pos);
      fwd_byte <= wr_cmd;
    end
  end

  assign rd_data = fwd ? fwd_byte : (odd_sel ? odd_q : even_q);

endmodule

`default_nettype wire

/* sv/ps2_command_queue_ack_resend.sv */
// ---------------------------------------------------------------------------
// PS/2 host command queue with ack and resend handling
// Queues command/argument pairs, sends one byte at a time and follows the
// device's ack and resend replies; other received bytes pass through.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  req_t
//   rsp      out        rsp_valid/rsp_stall  rsp_t
//   cfg      in         cfg_valid/cfg_ready  retry limit, 4 bits
//
// Each word passes ST_IDLE, where the accept updates the pointers, writes
// the store and issues its read, then ST_LOAD, which loads the store's
// registered read data into the output register; a stalled output holds
// ST_LOAD. Synchronous reset empties the queue and sets the retry limit to 5.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_command_queue_ack_resend #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ps2cq_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ps2cq_pkg::rsp_t rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data
);

  import ps2cq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  state_t        state, state_next;
  logic [PW-1:0] read_pos, read_pos_next;
  logic [PW-1:0] queued_count, queued_count_next;
  logic [3:0]    retry_count, retry_count_next;
  logic          awaiting_reply, awaiting_reply_next;
  logic [3:0]    retry_limit;
  logic [PW+1:0] fill_sum;
  logic          room;
  logic          is_reply;
  logic          do_send;
  logic          accept;
  logic          load_out;
  logic          wr_en;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] send_pos;
  rsp_t          res, res_q;
  rsp_t          load_word;
  logic [7:0]    rd_data;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign fill_sum  = {2'b00, read_pos} + {2'b00, queued_count} + (PW+2)'(2);
  assign room      = fill_sum < (PW+2)'(QUEUE_DEPTH);
  assign is_reply  = (req.rx_byte == ACK_CODE) || (req.rx_byte == RESEND_CODE);

  always_comb begin
    state_next          = state;
    read_pos_next       = read_pos;
    queued_count_next   = queued_count;
    retry_count_next    = retry_count;
    awaiting_reply_next = awaiting_reply;
    res                 = '0;
    do_send             = 1'b0;
    wr_en               = 1'b0;
    wr_pos              = '0;
    send_pos            = read_pos;
    load_out            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_LOAD;
          case (req.func)
            FUNC_ENQ: begin
              if (room) begin
                if (queued_count == '0) begin
                  read_pos_next = '0;
                end
                wr_pos            = read_pos_next + queued_count;
                wr_en             = 1'b1;
                queued_count_next = queued_count + PW'(2);
                if (awaiting_reply) begin
                  res.accepted = 1'b1;
                end else if (!req.ctrl_out_full) begin
                  res.accepted = 1'b1;
                  do_send      = 1'b1;
                end
              end
            end
            FUNC_RX: begin
              if (awaiting_reply && is_reply) begin
                awaiting_reply_next = 1'b0;
                if (req.rx_byte == ACK_CODE) begin
                  retry_count_next = '0;
                  do_send = (queued_count != '0) && !req.ctrl_out_full;
                end else if (retry_count >= retry_limit) begin
                  retry_count_next  = '0;
                  read_pos_next     = '0;
                  queued_count_next = '0;
                  res.gave_up       = 1'b1;
                end else if (read_pos != '0) begin
                  read_pos_next     = read_pos - PW'(1);
                  queued_count_next = queued_count + PW'(1);
                  retry_count_next  = retry_count + 4'd1;
                  do_send           = !req.ctrl_out_full;
                end
              end else begin
                res.pass_valid = 1'b1;
                res.pass_byte  = req.rx_byte;
                do_send = !awaiting_reply && (queued_count != '0) && !req.ctrl_out_full;
              end
            end
            FUNC_POLL: begin
              do_send = !awaiting_reply && (queued_count != '0) && !req.ctrl_out_full;
            end
            default: begin
            end
          endcase
          if (do_send) begin
            res.tx_valid        = 1'b1;
            send_pos            = read_pos_next;
            read_pos_next       = read_pos_next + PW'(1);
            queued_count_next   = queued_count_next - PW'(1);
            awaiting_reply_next = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        if (!rsp_valid || !rsp_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    load_word         = res_q;
    load_word.tx_byte = res_q.tx_valid ? rd_data : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      read_pos       <= '0;
      queued_count   <= '0;
      retry_count    <= '0;
      awaiting_reply <= 1'b0;
      retry_limit    <= RETRY_LIMIT_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        read_pos       <= read_pos_next;
        queued_count   <= queued_count_next;
        retry_count    <= retry_count_next;
        awaiting_reply <= awaiting_reply_next;
      end
      if (cfg_valid && cfg_ready) begin
        retry_limit <= cfg_data;
      end
      rsp_valid <= load_out || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
    if (load_out) begin
      rsp <= load_word;
    end
  end

  ps2cq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_pos  (wr_pos),
    .wr_cmd  (req.cmd_byte),
    .wr_arg  (req.arg_byte),
    .rd_en   (accept),
    .rd_pos  (send_pos),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

/* sv/ps2cq_checker.sv */
// ---------------------------------------------------------------------------
// PS/2 command queue checker
// Port-level checks on the command queue, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ps2cq_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input ps2cq_pkg::rsp_t rsp
);

  `ASSERT_CLK(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "word taken while busy")
  `ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled word moved")
  `ASSERT_CLK(a_tx_zero, rsp_valid && !rsp.tx_valid |-> rsp.tx_byte == 8'h00, "stray tx byte")
  `ASSERT_CLK(a_flush_quiet, rsp_valid && rsp.gave_up |-> !rsp.tx_valid && !rsp.pass_valid && !rsp.accepted, "flush with other result")
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !rsp_valid, "word after reset")

endmodule

bind ps2_command_queue_ack_resend ps2cq_checker u_ps2cq_checker (.*);

`default_nettype wire

/* tb/tb_ps2_command_queue_ack_resend.sv */
// ---------------------------------------------------------------------------
// PS/2 command queue testbench
// Drives command pairs, device replies and polls into the queue. A
// scoreboard predicts every reply word from its own copy of the queue
// state and compares it field by field. Both sides idle and stall in
// random bursts, and the retry limit is rewritten between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ps2_command_queue_ack_resend;
  import ps2cq_pkg::*;

  localparam int DEPTH        = 32;
  localparam int NPHASE       = 6;
  localparam int PHASE_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_SHOWN    = 40;

  class cmd_queue_scoreboard;
    logic [7:0]  slots [DEPTH];
    int unsigned rd_pos;
    int unsigned count;
    logic [3:0]  retries;
    logic [3:0]  limit;
    bit          waiting;
    rsp_t        replies_due [$];
    int          errors;
    int          n_sent;
    int          n_passed;
    int          n_refused;
    int          n_flushed;

    function new();
      rd_pos  = 0;
      count   = 0;
      retries = '0;
      limit   = RETRY_LIMIT_RESET;
      waiting = 1'b0;
      errors  = 0;
    endfunction

    function bit send_next(input bit full, inout rsp_t r);
      if (waiting) return 1'b0;
      if (count == 0) return 1'b1;
      if (full) return 1'b0;
      r.tx_valid = 1'b1;
      r.tx_byte  = slots[rd_pos];
      rd_pos++;
      count--;
      waiting = 1'b1;
      n_sent++;
      return 1'b1;
    endfunction

    function void note_request(input req_t it);
      rsp_t        r;
      int unsigned at;
      r = '0;
      case (it.func)
        FUNC_ENQ: begin
          if (rd_pos + count + 2 < DEPTH) begin
            if (count == 0) rd_pos = 0;
            at = rd_pos + count;
            slots[at]     = it.cmd_byte;
            slots[at + 1] = it.arg_byte;
            count += 2;
            if (!waiting) r.accepted = send_next(it.ctrl_out_full, r);
            else r.accepted = 1'b1;
          end else begin
            n_refused++;
          end
        end
        FUNC_RX: begin
          if (waiting && (it.rx_byte == ACK_CODE || it.rx_byte == RESEND_CODE)) begin
            waiting = 1'b0;
            if (it.rx_byte == ACK_CODE) begin
              retries = '0;
              if (count != 0) void'(send_next(it.ctrl_out_full, r));
            end else if (retries >= limit) begin
              retries   = '0;
              rd_pos    = 0;
              count     = 0;
              r.gave_up = 1'b1;
              n_flushed++;
            end else if (rd_pos != 0) begin
              rd_pos--;
              count++;
              retries = retries + 4'd1;
              void'(send_next(it.ctrl_out_full, r));
            end
          end else begin
            r.pass_valid = 1'b1;
            r.pass_byte  = it.rx_byte;
            n_passed++;
            if (!waiting && count != 0) void'(send_next(it.ctrl_out_full, r));
          end
        end
        FUNC_POLL: begin
          if (!waiting && count != 0) void'(send_next(it.ctrl_out_full, r));
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_reply(input rsp_t got);
      rsp_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("%0t: reply word expected none, actual %h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      compare("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare("tx_byte", want.tx_byte, got.tx_byte);
      compare("accepted", 8'(want.accepted), 8'(got.accepted));
      compare("pass_valid", 8'(want.pass_valid), 8'(got.pass_valid));
      compare("pass_byte", want.pass_byte, got.pass_byte);
      compare("gave_up", 8'(want.gave_up), 8'(got.gave_up));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_stall;
  rsp_t       rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;

  cmd_queue_scoreboard sb;
  bit quiet;
  bit hold_out;

  ps2_command_queue_ack_resend #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_reply(rsp);
  end

  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
        rsp_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic push_item(input req_t it, input bit may_idle);
    int gap;
    if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(it);
  endtask

  task automatic put(input func_t f, input logic [7:0] c, input logic [7:0] a,
                     input logic [7:0] rx, input logic full);
    req_t it;
    it.func          = f;
    it.cmd_byte      = c;
    it.arg_byte      = a;
    it.rx_byte       = rx;
    it.ctrl_out_full = full;
    push_item(it, 1'b0);
  endtask

  task automatic wait_for_replies();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [3:0] v);
    wait_for_replies();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed traffic that follows the reply state; flush by
  // repeated resends before the read position runs out of room
  function automatic req_t pick_item();
    req_t it;
    int   roll;
    it.cmd_byte      = 8'($urandom);
    it.arg_byte      = 8'($urandom);
    it.rx_byte       = 8'($urandom);
    it.ctrl_out_full = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      it.func = func_t'($urandom_range(0, 3));
    end else if (sb.waiting) begin
      it.func = FUNC_RX;
      if (roll < 25) it.func = FUNC_ENQ;
      else if (sb.rd_pos + sb.count >= DEPTH - 6)
        it.rx_byte = ($urandom_range(0, 99) < 65) ? RESEND_CODE : ACK_CODE;
      else if (roll < 65) it.rx_byte = ACK_CODE;
      else if (roll < 85) it.rx_byte = RESEND_CODE;
    end else if (sb.count != 0) begin
      if (roll < 50) it.func = FUNC_POLL;
      else if (roll < 80) it.func = FUNC_ENQ;
      else it.func = FUNC_RX;
    end else begin
      if (roll < 70) it.func = FUNC_ENQ;
      else if (roll < 90) it.func = FUNC_RX;
      else it.func = FUNC_POLL;
    end
    // never ack the last byte high in the buffer: nothing could free it
    if (it.func == FUNC_RX && it.rx_byte == ACK_CODE && sb.waiting &&
        sb.count == 0 && sb.rd_pos >= DEPTH - 2)
      it.rx_byte = RESEND_CODE;
    return it;
  endfunction

  initial begin
    logic [3:0] limits [NPHASE];
    sb        = new();
    quiet     = 1'b0;
    hold_out  = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    limits[0] = 4'd0;
    limits[1] = 4'd15;
    limits[2] = 4'd1;
    limits[3] = 4'($urandom_range(2, 14));
    limits[4] = 4'd15;
    limits[5] = 4'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put(FUNC_POLL, 8'h00, 8'h00, 8'h00, 1'b0);
    put(FUNC_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, RESEND_CODE, 1'b1);
    put(FUNC_ENQ, 8'hFF, 8'h00, 8'h00, 1'b1);
    put(FUNC_POLL, 8'h00, 8'h00, 8'h00, 1'b1);
    put(FUNC_POLL, 8'h00, 8'h00, 8'h00, 1'b0);
    put(FUNC_ENQ, 8'h00, 8'hFF, 8'h00, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, 8'h00, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, RESEND_CODE, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b1);
    put(FUNC_RX, 8'h00, 8'h00, 8'hFF, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b0);
    put(FUNC_ENQ, 8'hA5, 8'h5A, 8'h00, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, ACK_CODE, 1'b0);
    put(FUNC_ENQ, 8'h12, 8'h34, 8'h00, 1'b0);
    put(FUNC_RX, 8'h00, 8'h00, RESEND_CODE, 1'b0);
    put(FUNC_POLL, 8'h00, 8'h00, 8'h00, 1'b0);
    repeat (6) put(FUNC_RX, 8'h00, 8'h00, RESEND_CODE, 1'b0);

    for (int ph = 0; ph < NPHASE; ph++) begin
      write_limit(limits[ph]);
      quiet = (ph == 3) || (ph == NPHASE - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == PHASE_ITEMS / 2) begin
          hold_out = 1'b1;
          repeat (40) push_item(pick_item(), 1'b0);
          while (hold_out) @(posedge clk);
        end
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_for_replies();
        push_item(pick_item(), 1'b1);
      end
    end

    wait_for_replies();
    repeat (6) @(posedge clk);
    $display("run covered %0d bytes sent, %0d bytes passed on, %0d pairs refused, %0d flushes",
             sb.n_sent, sb.n_passed, sb.n_refused, sb.n_flushed);
    $display("retry limits used: 5 after reset, then 0, 15, 1, %0d, 15 and 0", limits[3]);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
